FILE: design/ssmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmp_pkg
// Shared widths, payload types and the result record of the spaced-site
// maximum-profit selector.
// ----------------------------------------------------------------------------
package ssmp_pkg;

    localparam int POS_W    = 20;
    localparam int PROFIT_W = 10;
    localparam int TOTAL_W  = 17;

    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [PROFIT_W-1:0] t_profit;
    typedef logic [TOTAL_W-1:0]  t_total;

    localparam t_total TOTAL_MAX = '1;

    typedef struct packed {
        t_total max_profit;
        logic   overflow;
    } t_result;

endpackage

FILE: design/ssmp_site_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmp_site_mem
// Site store: one write port and one read port, read data registered.
// Each entry holds a site position and the best total ending at that site.
// ----------------------------------------------------------------------------
module ssmp_site_mem #(
    parameter int DEPTH = 128,
    parameter int IDX_W = 7
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  ssmp_pkg::t_pos       i_wpos,
    input  ssmp_pkg::t_total     i_wtot,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output ssmp_pkg::t_pos       o_rd_pos,
    output ssmp_pkg::t_total     o_rd_tot
);
    import ssmp_pkg::*;

    t_pos   r_pos_mem [DEPTH];
    t_total r_tot_mem [DEPTH];
    t_pos   r_rd_pos;
    t_total r_rd_tot;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pos_mem[i_waddr] <= i_wpos;
            r_tot_mem[i_waddr] <= i_wtot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_pos <= r_pos_mem[i_rd_addr];
            r_rd_tot <= r_tot_mem[i_rd_addr];
        end
    end

    assign o_rd_pos = r_rd_pos;
    assign o_rd_tot = r_rd_tot;

endmodule

FILE: design/ssmp_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmp_scan
// Sequencer: scans the stored sites of the current set, takes the best
// qualifying total, writes the new site back and closes a set on last.
// ----------------------------------------------------------------------------
module ssmp_scan #(
    parameter int MAX_SITES = 128,
    parameter int IDX_W     = 7,
    parameter int CNT_W     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssmp_pkg::t_pos       i_min_gap,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ssmp_pkg::t_pos       i_pos,
    input  ssmp_pkg::t_profit    i_profit,
    input  logic                 i_last,
    output logic                 o_res_vld,
    output ssmp_pkg::t_result    o_res,
    input  logic                 i_res_take,
    output logic                 o_rd_en,
    output logic [IDX_W-1:0]     o_rd_addr,
    input  ssmp_pkg::t_pos       i_rd_pos,
    input  ssmp_pkg::t_total     i_rd_tot,
    output logic                 o_we,
    output logic [IDX_W-1:0]     o_waddr,
    output ssmp_pkg::t_pos       o_wpos,
    output ssmp_pkg::t_total     o_wtot
);
    import ssmp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    t_total            r_best;
    logic              r_dropped;
    logic [IDX_W-1:0]  r_rd_addr;
    logic              r_rd_vld;

    // per-item payload
    t_pos              r_pos;
    t_pos              r_thr;
    logic              r_thr_neg;
    t_profit           r_profit;
    logic              r_last;
    t_total            r_prior;

    logic              accept;
    logic              full;
    logic              last_issue;
    logic [POS_W:0]    thr;
    logic              qual;
    logic [TOTAL_W:0]  sum;
    t_total            total;

    assign accept     = i_valid && o_ready;
    assign full       = (r_count == CNT_W'(MAX_SITES));
    assign last_issue = ((CNT_W'(r_rd_addr) + CNT_W'(1)) == r_count);
    assign thr        = {1'b0, i_pos} - {1'b0, i_min_gap};

    // stored site qualifies when its position lies below new position - gap
    assign qual = r_rd_vld && !r_thr_neg && (i_rd_pos < r_thr) && (i_rd_tot > r_prior);

    assign sum   = {1'b0, r_prior} + {{(TOTAL_W + 1 - PROFIT_W){1'b0}}, r_profit};
    assign total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (full) begin
                        n_state = i_last ? S_EMIT : S_IDLE;
                    end else if (r_count == '0) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_WRITE;
            S_WRITE: n_state = r_last ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_best    <= '0;
            r_dropped <= 1'b0;
            r_rd_addr <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            case (r_state)
                S_IDLE: begin
                    r_rd_addr <= '0;
                    if (accept && full) begin
                        r_dropped <= 1'b1;
                    end
                end
                S_SCAN: r_rd_addr <= r_rd_addr + IDX_W'(1);
                S_WRITE: begin
                    r_count <= r_count + CNT_W'(1);
                    if (total > r_best) begin
                        r_best <= total;
                    end
                end
                S_EMIT: begin
                    if (i_res_take) begin
                        r_count   <= '0;
                        r_best    <= '0;
                        r_dropped <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // item payload and running maximum; no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos     <= i_pos;
            r_thr     <= thr[POS_W-1:0];
            r_thr_neg <= thr[POS_W];
            r_profit  <= i_profit;
            r_last    <= i_last;
            r_prior   <= '0;
        end else if (qual) begin
            r_prior <= i_rd_tot;
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_rd_en   = (r_state == S_SCAN);
    assign o_rd_addr = r_rd_addr;
    assign o_we      = (r_state == S_WRITE);
    assign o_waddr   = r_count[IDX_W-1:0];
    assign o_wpos    = r_pos;
    assign o_wtot    = total;

    assign o_res_vld        = (r_state == S_EMIT);
    assign o_res.max_profit = r_best;
    assign o_res.overflow   = r_dropped;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SITES))
        else $error("site count above capacity");

    a_read_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (CNT_W'(o_rd_addr) < r_count))
        else $error("scan reads beyond stored sites");

    a_write_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> !full)
        else $error("write into a full store");

    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full) |=> r_dropped)
        else $error("dropped site did not set overflow");

    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && i_res_take) |=> (r_count == '0 && r_best == '0 && !r_dropped))
        else $error("set state not cleared after result");

endmodule

FILE: design/spaced_site_max_profit_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spaced_site_max_profit_dp
// Best total profit over sites chosen with a minimum spacing, one set of
// ascending sites per frame, one result beat per frame.
// ----------------------------------------------------------------------------
// Sites arrive on the slave stream, one beat each, and a set ends on the beat
// with tlast. Each site stored so far is read back once from the site memory
// (one read port, one entry a cycle); a drain step and the write-back of the
// new site follow before the next ready. When the set is still empty a site
// goes straight to the write-back, and when the store is full it is dropped.
// The tlast beat adds an emit state that hands the result to the output
// register once it can take it; the register holds it while the next set is
// already being accepted. Reads and the write-back of a site never overlap, so the
// memory needs no forwarding. Write min_gap only while no set is in progress.
module spaced_site_max_profit_dp #(
    parameter int MAX_SITES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: min_gap
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_data,
    // site stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [19:0] position, [29:20] profit, rest zero
    input  logic        i_s_tlast,   // last site of the set
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [16:0] max_profit, rest zero
    output logic        o_m_tuser    // [0] overflow
);
    import ssmp_pkg::*;

    localparam int IDX_W = $clog2(MAX_SITES);
    localparam int CNT_W = $clog2(MAX_SITES + 1);

    t_pos             r_min_gap;
    logic             r_out_vld;
    t_result          r_out;

    t_result          res;
    logic             res_vld;
    logic             res_take;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_pos             rd_pos;
    t_total           rd_tot;
    logic             we;
    logic [IDX_W-1:0] waddr;
    t_pos             wpos;
    t_total           wtot;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= '0;
        end else if (i_cfg_valid) begin
            r_min_gap <= i_cfg_data;
        end
    end

    // output register: load when empty or being drained this cycle
    assign res_take = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_vld) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(24 - TOTAL_W){1'b0}}, r_out.max_profit};
    assign o_m_tuser  = r_out.overflow;

    ssmp_scan #(
        .MAX_SITES (MAX_SITES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_min_gap  (r_min_gap),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_pos      (i_s_tdata[POS_W-1:0]),
        .i_profit   (i_s_tdata[POS_W+PROFIT_W-1:POS_W]),
        .i_last     (i_s_tlast),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_take (res_take),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_pos   (rd_pos),
        .i_rd_tot   (rd_tot),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wpos     (wpos),
        .o_wtot     (wtot)
    );

    ssmp_site_mem #(
        .DEPTH (MAX_SITES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wpos    (wpos),
        .i_wtot    (wtot),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_pos  (rd_pos),
        .o_rd_tot  (rd_tot)
    );

endmodule

FILE: test/tb_spaced_site_max_profit_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spaced_site_max_profit_dp
// Self-checking bench for the spaced-site maximum-profit selector. A short
// table of hand-picked sites comes first. Then random sets of sites run over
// several min_gap settings. An in-bench scorer tracks the stored sites and
// totals, and every result beat is checked against the table or the scorer.
// ----------------------------------------------------------------------------
module tb_spaced_site_max_profit_dp;

    import ssmp_pkg::*;

    localparam int SITE_CAP    = 128;   // store depth of the block under test
    localparam int ITEMS_TOTAL = 1850;  // stop sending random sets past this count
    localparam int PHASE_ITEMS = 150;   // sites per min_gap setting
    localparam int SETTLE_CYC  = 150;   // covers one full scan of the store
    localparam t_pos POS_MAX   = '1;

    // One row of the hand-picked table. Rows marked known carry the result
    // that the set obviously yields; the scorer supplies all others.
    typedef struct packed {
        t_pos    pos;
        t_profit gain;
        logic    last;
        logic    known;
        t_total  exp_max;
        logic    exp_ov;
    } t_site_row;

    localparam int N_ROWS = 16;
    localparam t_site_row DIRECTED [N_ROWS] = '{
        // single site at position zero with no profit
        '{20'd0,       10'd0,    1'b1, 1'b1, 17'd0,    1'b0},
        // single site at the top position with the top profit
        '{20'hFFFFF,   10'd1023, 1'b1, 1'b1, 17'd1023, 1'b0},
        // both ends of the position range chain together
        '{20'd0,       10'd1023, 1'b0, 1'b0, 17'd0,    1'b0},
        '{20'hFFFFF,   10'd1023, 1'b1, 1'b1, 17'd2046, 1'b0},
        // equal positions: second site finds no predecessor
        '{20'd100,     10'd5,    1'b0, 1'b0, 17'd0,    1'b0},
        '{20'd100,     10'd7,    1'b1, 1'b1, 17'd7,    1'b0},
        // descending positions: second site stands alone
        '{20'd500,     10'd10,   1'b0, 1'b0, 17'd0,    1'b0},
        '{20'd0,       10'd20,   1'b1, 1'b1, 17'd20,   1'b0},
        // short ascending chain
        '{20'd10,      10'd300,  1'b0, 1'b0, 17'd0,    1'b0},
        '{20'd11,      10'd200,  1'b0, 1'b0, 17'd0,    1'b0},
        '{20'd12,      10'd250,  1'b0, 1'b0, 17'd0,    1'b0},
        '{20'd40,      10'd100,  1'b1, 1'b0, 17'd0,    1'b0},
        // out-of-order site in the middle of a set
        '{20'd1,       10'd1,    1'b0, 1'b0, 17'd0,    1'b0},
        '{20'd3,       10'd2,    1'b0, 1'b0, 17'd0,    1'b0},
        '{20'd2,       10'd9,    1'b0, 1'b0, 17'd0,    1'b0},
        '{20'd7,       10'd4,    1'b1, 1'b0, 17'd0,    1'b0}
    };

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [19:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;    // [19:0] position, [29:20] profit, rest zero
    logic        i_s_tlast;    // last site of the set
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;    // [16:0] max_profit, rest zero
    logic        o_m_tuser;    // [0] overflow

    spaced_site_max_profit_dp #(
        .MAX_SITES (SITE_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // ------------------------------------------------------------------------
    // Scorer state: a private copy of the site store and the set registers
    // ------------------------------------------------------------------------
    t_pos    stored_pos   [SITE_CAP];
    t_total  stored_total [SITE_CAP];
    int      stored_n;
    t_total  run_best;
    logic    dropped;
    t_pos    gap_cfg;

    t_result pending_totals [$];   // results owed by the block, oldest first
    t_result want;

    int      n_errors;
    int      n_items;
    int      n_results;
    int      n_overflow_sets;
    int      n_cfg;
    int      burst_left;
    bit      gaps_on;

    logic [15:0] stall_pat = 16'hFFFF;
    logic [3:0]  stall_idx = '0;

    // Score one accepted site; return 1 when the beat closes a set, with
    // the result that set owes in res.
    function automatic bit score_site(input t_pos pos, input t_profit gain,
                                      input logic last, output t_result res);
        t_total            prior;
        logic [TOTAL_W:0]  sum;
        logic [POS_W:0]    reach;
        prior = '0;
        if (stored_n < SITE_CAP) begin
            // best total among earlier sites lying strictly beyond the gap
            for (int j = 0; j < stored_n; j++) begin
                reach = {1'b0, stored_pos[j]} + {1'b0, gap_cfg};
                if ({1'b0, pos} > reach && stored_total[j] > prior)
                    prior = stored_total[j];
            end
            sum = {1'b0, prior} + {8'b0, gain};
            if (sum > {1'b0, TOTAL_MAX})
                sum = {1'b0, TOTAL_MAX};
            stored_pos[stored_n]   = pos;
            stored_total[stored_n] = sum[TOTAL_W-1:0];
            stored_n++;
            if (sum[TOTAL_W-1:0] > run_best)
                run_best = sum[TOTAL_W-1:0];
        end else begin
            // store full: drop the site, remember it for the result
            dropped = 1'b1;
        end
        res = '{max_profit: run_best, overflow: dropped};
        if (last) begin
            stored_n = 0;
            run_best = '0;
            dropped  = 1'b0;
        end
        return last;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a 16-bit pattern that each phase reloads
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_m_tready <= stall_pat[stall_idx];
        stall_idx  <= stall_idx + 4'd1;
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted beat with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_totals.size() == 0) begin
                $display("%0t ERROR: result beat with none expected: max_profit=%0d overflow=%0d",
                         $time, o_m_tdata[TOTAL_W-1:0], o_m_tuser);
                n_errors++;
            end else begin
                want = pending_totals.pop_front();
                n_results++;
                if (want.overflow)
                    n_overflow_sets++;
                if (o_m_tdata[TOTAL_W-1:0] !== want.max_profit) begin
                    $display("%0t ERROR: max_profit expected %0d, got %0d",
                             $time, want.max_profit, o_m_tdata[TOTAL_W-1:0]);
                    n_errors++;
                end
                if (o_m_tuser !== want.overflow) begin
                    $display("%0t ERROR: overflow expected %0d, got %0d",
                             $time, want.overflow, o_m_tuser);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers. Each starts and ends just after a falling edge.
    // ------------------------------------------------------------------------

    // Send one site beat; with gaps on, the sender idles between bursts of random length.
    // Valid stays high across back-to-back beats inside a burst.
    task automatic send_site(input t_pos pos, input t_profit gain, input logic last,
                             input logic known, input t_result known_res);
        t_result res;
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, gain, pos};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        n_items++;
        if (score_site(pos, gain, last, res))
            pending_totals.push_back(known ? known_res : res);
        @(negedge i_clk);
    endtask

    // Drain all owed results, let the last scan finish, then write min_gap.
    task automatic load_gap(input t_pos g);
        i_s_tvalid <= 1'b0;
        while (pending_totals.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        gap_cfg = g;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int      p;
        int      k;
        int      len;
        int      phase_items;
        int      next_pos;
        int      step;
        bit      noisy;
        t_pos    g;
        t_profit gain;
        t_result none;

        none            = '0;
        n_errors        = 0;
        n_items         = 0;
        n_results       = 0;
        n_overflow_sets = 0;
        n_cfg           = 0;
        burst_left      = 0;
        gaps_on         = 1'b1;
        stored_n        = 0;
        run_best        = '0;
        dropped         = 1'b0;
        gap_cfg         = '0;

        // hold every input at a known value through reset
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // hand-picked table at the reset value of min_gap
        for (int r = 0; r < N_ROWS; r++)
            send_site(DIRECTED[r].pos, DIRECTED[r].gain, DIRECTED[r].last,
                      DIRECTED[r].known,
                      '{max_profit: DIRECTED[r].exp_max, overflow: DIRECTED[r].exp_ov});

        // random sets, one min_gap setting per phase
        p = 0;
        while (n_items < ITEMS_TOTAL) begin
            case (p % 8)
                0:       g = '0;
                1:       g = POS_MAX;
                2:       g = 20'd1;
                3:       g = t_pos'($urandom_range(0, 15));
                4:       g = t_pos'($urandom_range(16, 4095));
                5:       g = t_pos'($urandom);
                6:       g = t_pos'($urandom_range(0, 255));
                default: g = 20'h80000;
            endcase
            load_gap(g);
            gaps_on = (p % 3 != 2);
            if (p % 4 == 3)
                stall_pat = 16'hFFFF;
            else if (p % 4 == 1)
                stall_pat = 16'($urandom & $urandom) | 16'h0001;
            else
                stall_pat = 16'($urandom) | 16'h0001;

            if (p % 8 == 0) begin
                // fill the store with top profits and push past it:
                // every site chains, extras are dropped
                for (k = 0; k < SITE_CAP + 3; k++)
                    send_site(t_pos'(k), 10'd1023, k == SITE_CAP + 2, 1'b1,
                              '{max_profit: 17'd130944, overflow: 1'b1});
            end

            phase_items = 0;
            while (phase_items < PHASE_ITEMS && n_items < ITEMS_TOTAL) begin
                // mostly short sets, now and then one near or past capacity
                if ($urandom_range(0, 24) == 0)
                    len = $urandom_range(SITE_CAP - 8, SITE_CAP + 8);
                else
                    len = $urandom_range(1, 12);
                noisy = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 3) == 0)
                    next_pos = $urandom_range(0, POS_MAX);
                else
                    next_pos = $urandom_range(0, 4095);
                for (k = 0; k < len; k++) begin
                    case ($urandom_range(0, 9))
                        0:       gain = '0;
                        1:       gain = '1;
                        default: gain = t_profit'($urandom);
                    endcase
                    send_site(noisy ? t_pos'($urandom) : t_pos'(next_pos), gain,
                              k == len - 1, 1'b0, none);
                    // advance around the gap boundary so sites land on both sides
                    case ($urandom_range(0, 3))
                        0:       step = int'(gap_cfg);
                        1:       step = int'(gap_cfg) + 1;
                        default: step = $urandom_range(0, 2 * int'(gap_cfg) + 2);
                    endcase
                    next_pos = next_pos + step;
                    if (next_pos > int'(POS_MAX))
                        next_pos = int'(POS_MAX);
                end
                phase_items += len;
            end
            p++;
        end

        // drain, then give the block time to show any stray beat
        i_s_tvalid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYC) @(posedge i_clk);

        $display("Run covered %0d sites and %0d checked sets (%0d with dropped sites),",
                 n_items, n_results, n_overflow_sets);
        $display("over %0d min_gap settings; %0d mismatches.", n_cfg, n_errors);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog: far beyond the slowest legal run
    // ------------------------------------------------------------------------
    initial begin
        #10_000_000;
        $display("%0t ERROR: timeout with %0d results still owed", $time,
                 pending_totals.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
design/ssmp_pkg.sv
design/ssmp_site_mem.sv
design/ssmp_scan.sv
design/spaced_site_max_profit_dp.sv
test/tb_spaced_site_max_profit_dp.sv
